// ===== hw/rtl/cmix_pkg.sv =====
// Package: shared widths, constants and the divider beat type for the RGBA mixer.
`default_nettype none
package cmix_pkg;
    localparam int unsigned ChanW   = 8;
    localparam int unsigned WeightW = 16;
    localparam int unsigned NumW    = 24;
    localparam int unsigned NumChan = 3;
    localparam int unsigned Lanes   = 8;   // quotient bits, one cell each
    localparam logic [WeightW-1:0] FullScale = 16'd255;

    typedef struct packed {
        logic                           valid;
        logic                           ge;      // total weight >= 255
        logic [ChanW-1:0]               alpha;
        logic [WeightW-1:0]             total;
        logic [NumChan-1:0][NumW-1:0]   rem;
        logic [NumChan-1:0][ChanW-1:0]  quo;
    } t_div_beat;
endpackage
`default_nettype wire

// ===== hw/rtl/cmix_weigh.sv =====
// Front end: weights, summed weight, alpha and channel numerators over two stages.
`default_nettype none
module cmix_weigh (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [3:0][cmix_pkg::ChanW-1:0] i_dst,   // r,g,b,a
    input  wire logic [3:0][cmix_pkg::ChanW-1:0] i_src,   // r,g,b,a
    input  wire logic [cmix_pkg::ChanW-1:0]   i_coverage,
    output cmix_pkg::t_div_beat               o_beat
);
    logic                                  r_v1;
    logic [cmix_pkg::WeightW-1:0]          r_wd, r_ws, r_total;
    logic [2:0][cmix_pkg::ChanW-1:0]       r_d, r_s;
    cmix_pkg::t_div_beat                   r_beat;
    logic [cmix_pkg::WeightW-1:0]          n_wd, n_ws;
    logic [cmix_pkg::WeightW:0]            n_alpha_sum;

    assign n_wd = cmix_pkg::WeightW'(i_dst[3]) * cmix_pkg::WeightW'(i_coverage);
    assign n_ws = cmix_pkg::WeightW'(i_src[3]) *
                  cmix_pkg::WeightW'(8'd255 - i_coverage);
    // x/255 == (x + (x>>8) + 1) >> 8 for x below 65535
    assign n_alpha_sum = {1'b0, r_total} + 17'(r_total >> 8) + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_v1         <= i_valid;
            r_beat.valid <= r_v1;
        end
        if (i_en) begin
            r_wd    <= n_wd;
            r_ws    <= n_ws;
            r_total <= n_wd + n_ws;
            for (int c = 0; c < 3; c++) begin
                r_d[c] <= i_dst[c];
                r_s[c] <= i_src[c];
            end
            r_beat.ge    <= (r_total >= cmix_pkg::FullScale);
            r_beat.alpha <= n_alpha_sum[15:8];
            r_beat.total <= r_total;
            for (int c = 0; c < 3; c++) begin
                r_beat.rem[c] <= cmix_pkg::NumW'(r_d[c]) * cmix_pkg::NumW'(r_wd)
                               + cmix_pkg::NumW'(r_s[c]) * cmix_pkg::NumW'(r_ws);
                r_beat.quo[c] <= '0;
            end
        end
    end
    assign o_beat = r_beat;
endmodule
`default_nettype wire

// ===== hw/rtl/cmix_div_cell.sv =====
// Divider cell: settles one quotient bit for all three color lanes.
`default_nettype none
module cmix_div_cell #(
    parameter int unsigned BIT = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire cmix_pkg::t_div_beat i_beat,
    output cmix_pkg::t_div_beat      o_beat
);
    cmix_pkg::t_div_beat r_beat, n_beat;
    logic [cmix_pkg::NumW-1:0] n_div;

    assign n_div = cmix_pkg::NumW'(i_beat.total) << BIT;

    always_comb begin
        n_beat = i_beat;
        for (int c = 0; c < cmix_pkg::NumChan; c++) begin
            if (i_beat.rem[c] >= n_div) begin
                n_beat.rem[c]      = i_beat.rem[c] - n_div;
                n_beat.quo[c][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat.valid <= n_beat.valid;
        end
        if (i_en) begin
            r_beat.ge    <= n_beat.ge;
            r_beat.alpha <= n_beat.alpha;
            r_beat.total <= n_beat.total;
            r_beat.rem   <= n_beat.rem;
            r_beat.quo   <= n_beat.quo;
        end
    end
    assign o_beat = r_beat;
endmodule
`default_nettype wire

// ===== hw/rtl/coverage_weighted_rgba_mix.sv =====
// Top level: coverage-weighted blend of two RGBA8 pixels, one pixel per clock when downstream does not stall.
//
//  channel  | dir | tdata fields (low bit up)                       | bits
//  s_axis   | in  | dst r,g,b,a, src r,g,b,a, coverage              | 72
//  m_axis   | out | out r,g,b,a                                     | 32
//
// Throughput one beat per clock while downstream does not stall; the path holds
// 2 front-end stages, 8 divider cells and 1 output register. The chain of restoring
// divider cells, one quotient bit per cell, sets the depth.
// Synchronous active-low reset clears all valid flags; no clearing pass.
// Downstream stall freezes the whole chain; s_axis tready drops with it.
`default_nettype none
module coverage_weighted_rgba_mix (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // dst_red, dst_green, dst_blue, dst_alpha, src_red, src_green, src_blue,
    // src_alpha, coverage
    input  wire logic [71:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]      o_m_axis_tdata
);
    localparam int unsigned W = cmix_pkg::ChanW;

    logic en;
    logic [3:0][W-1:0] dst, src;
    cmix_pkg::t_div_beat chain [cmix_pkg::Lanes+1];
    cmix_pkg::t_div_beat tail;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    // whole pipe advances when the output slot is empty or being drained
    assign en = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            dst[c] = i_s_axis_tdata[c*W +: W];
            src[c] = i_s_axis_tdata[(c+4)*W +: W];
        end
    end

    cmix_weigh u_weigh (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_s_axis_tvalid),
        .i_dst      (dst),
        .i_src      (src),
        .i_coverage (i_s_axis_tdata[71:64]),
        .o_beat     (chain[0])
    );

    // MSB cell first: quotient < 256 since num <= 255 * total
    for (genvar k = 0; k < cmix_pkg::Lanes; k++) begin : g_cell
        cmix_div_cell #(.BIT(cmix_pkg::Lanes-1-k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_beat  (chain[k]),
            .o_beat  (chain[k+1])
        );
    end

    assign tail = chain[cmix_pkg::Lanes];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= tail.valid;
        end
        if (en) begin
            // low total weight forces all four channels to zero
            r_out_data <= tail.ge ? {tail.alpha, tail.quo[2], tail.quo[1], tail.quo[0]}
                                  : 32'd0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
endmodule
`default_nettype wire

// ===== hw/rtl/cmix_checker.sv =====
// Port-level checker for the RGBA mixer, bound to the top level.
`default_nettype none
module cmix_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata
);
    // held result stays put while downstream stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat changed under stall");

    // zero alpha only comes from the low-weight case, which zeroes color too
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[31:24] == 8'd0) |-> o_m_axis_tdata[23:0] == 24'd0)
        else $error("color nonzero with zero alpha");

    // ready follows the output slot
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input stalled with free output slot");

    a_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");
endmodule

bind coverage_weighted_rgba_mix cmix_port_checker u_cmix_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

// ===== verif/cmix_checker.sv =====
// Checker: watches both stream channels, predicts each blended pixel, compares.
`timescale 1ns / 1ps
module cmix_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [71:0] i_s_axis_tdata,
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [31:0] i_m_axis_tdata,
    output int               o_errors,
    output int               o_pending,
    output int               o_pixels_in,
    output int               o_pixels_out
);
    logic [31:0] pixel_q[$];

    function automatic logic [31:0] blend_pixel(input logic [71:0] px);
        logic [31:0] wd, ws, tot, cov;
        logic [31:0] res;
        cov = 32'(px[71:64]);
        wd  = 32'(px[31:24]) * cov;
        ws  = 32'(px[63:56]) * (32'(cmix_pkg::FullScale) - cov);
        tot = wd + ws;
        res = '0;
        if (tot >= 32'(cmix_pkg::FullScale)) begin
            for (int c = 0; c < 3; c++) begin
                res[c*8 +: 8] = 8'((32'(px[c*8 +: 8]) * wd
                                    + 32'(px[32 + c*8 +: 8]) * ws) / tot);
            end
            res[31:24] = 8'(tot / 32'(cmix_pkg::FullScale));
        end
        return res;
    endfunction

    assign o_pending = pixel_q.size();

    always @(posedge i_clk) begin
        logic [31:0] exp_px;
        int          n_err;
        n_err = 0;
        if (!i_rst_n) begin
            o_errors     <= 0;
            o_pixels_in  <= 0;
            o_pixels_out <= 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                pixel_q.push_back(blend_pixel(i_s_axis_tdata));
                o_pixels_in <= o_pixels_in + 1;
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_pixels_out <= o_pixels_out + 1;
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual %h",
                             $time, i_m_axis_tdata);
                    n_err = n_err + 1;
                end else begin
                    exp_px = pixel_q.pop_front();
                    for (int c = 0; c < 4; c++) begin
                        if (exp_px[c*8 +: 8] !== i_m_axis_tdata[c*8 +: 8]) begin
                            $display("%0t: channel %0d: expected %h, actual %h",
                                     $time, c, exp_px[c*8 +: 8],
                                     i_m_axis_tdata[c*8 +: 8]);
                            n_err = n_err + 1;
                        end
                    end
                end
            end
            if (n_err != 0) begin
                o_errors <= o_errors + n_err;
            end
        end
    end
endmodule

// ===== verif/tb_top.sv =====
// Testbench top: clock, reset, pixel stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
    localparam int RandPixels = 1530;
    localparam int Latency    = 11;
    localparam int IdleLimit  = 2000;    // well above the longest random gaps plus pipeline depth

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;          // dst r,g,b,a, src r,g,b,a, coverage
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;          // out r,g,b,a
    int          errors, pending, pixels_in, pixels_out;
    int          idle_cycles;
    bit          stall_mode;       // random gaps when set; runs with no gaps at all when clear

    coverage_weighted_rgba_mix uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    cmix_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending),
        .o_pixels_in(pixels_in), .o_pixels_out(pixels_out)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Watchdog: count cycles where neither side moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("timeout after %0d idle cycles, %0d beats pending",
                         idle_cycles, pending);
                $display("coverage_weighted_rgba_mix regression: fail");
                $finish;
            end
        end
    end

    // Sink: random stall per beat, with bursts of no stalling.
    initial begin
        int wait_n;
        m_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_n = stall_mode ? $urandom_range(0, 19) : 0;
            repeat (wait_n) begin
                m_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    // Send one pixel after a random gap; tvalid stays high across back-to-back beats.
    task automatic send_pixel(input logic [71:0] px);
        int gap;
        gap = stall_mode ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    function automatic logic [71:0] mk_pixel(input logic [31:0] dst, input logic [31:0] src,
                                            input logic [7:0] cov);
        return {cov, src, dst};
    endfunction

    initial begin
        logic [31:0] dst, src;
        logic [7:0]  cov;
        int          drain;
        idle_cycles = 0;
        stall_mode  = 1'b1;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: coverage extremes, alpha extremes, low-weight zero case.
        send_pixel(mk_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF));
        send_pixel(mk_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 8'h00));
        send_pixel(mk_pixel('0, '0, 8'h00));
        send_pixel(mk_pixel('0, '0, 8'hFF));
        send_pixel(mk_pixel(32'hFF102030, 32'h00FFFFFF, 8'hFF));
        send_pixel(mk_pixel(32'h00FFFFFF, 32'hFF405060, 8'h00));
        send_pixel(mk_pixel(32'h01FFFFFF, 32'h00FFFFFF, 8'h01));   // weight 1: zero out
        send_pixel(mk_pixel(32'h00FFFFFF, 32'h01FFFFFF, 8'hFE));   // weight 1: zero out
        send_pixel(mk_pixel(32'h01AA55AA, 32'h0155AA55, 8'h80));   // weight 255: just enough
        send_pixel(mk_pixel(32'h00FFFFFF, 32'h00FFFFFF, 8'h80));   // both alphas zero
        send_pixel(mk_pixel(32'hFFFF00FF, 32'hFF00FF00, 8'h80));
        send_pixel(mk_pixel(32'h80FFFFFF, 32'h7F000000, 8'h7F));
        send_pixel(mk_pixel(32'hFF000000, 32'h01FFFFFF, 8'hFE));
        send_pixel(mk_pixel(32'h01FFFFFF, 32'hFF000000, 8'h01));
        send_pixel(mk_pixel(32'hAA55AA55, 32'h55AA55AA, 8'hAA));
        send_pixel(mk_pixel(32'h55AA55AA, 32'hAA55AA55, 8'h55));

        // Random: mostly full range, some low alphas to hit the zero branch,
        // some extreme coverage; every fourth block of 100 runs without gaps.
        for (int n = 0; n < RandPixels; n++) begin
            stall_mode = ((n / 100) % 4) != 3;
            dst = $urandom;
            src = $urandom;
            cov = $urandom_range(0, 255);
            case ($urandom_range(0, 5))
                0: begin
                    dst[31:24] = $urandom_range(0, 2);
                    src[31:24] = $urandom_range(0, 2);
                end
                1: cov = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                2: cov = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
                default: ;
            endcase
            send_pixel(mk_pixel(dst, src, cov));
        end
        s_tvalid <= 1'b0;
        stall_mode = 1'b1;

        while (pending != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 4 * Latency) begin
            @(posedge i_clk);
            drain++;
        end

        $display("sent %0d pixels, checked %0d blended pixels", pixels_in, pixels_out);
        $display("covered coverage and alpha extremes, the low-weight zero case, random stalls");
        if (errors == 0 && pending == 0) begin
            $display("coverage_weighted_rgba_mix regression: pass");
        end else begin
            $display("coverage_weighted_rgba_mix regression: fail");
        end
        $finish;
    end
endmodule
